@@ hdl/assert_macros.svh @@
// Assertion macros used by the datapath of the run-length image decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define RLID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define RLID_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define RLID_ASSERT(label, prop, msg)
`define RLID_NEVER(label, expr, msg)
`endif
`endif

@@ hdl/rlid_pkg.sv @@
// Shared types and constants of the run-length image decoder.
package rlid_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X     = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y     = 2'd3;

  // Reset values and width limits.
  localparam logic [12:0] WIDTH_RESET  = 13'd320;
  localparam logic [12:0] HEIGHT_RESET = 13'd200;
  localparam logic [12:0] WIDTH_MIN    = 13'd128;
  localparam logic [12:0] WIDTH_MAX    = 13'd4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the offered token into the datapath
    logic step;   // produce one segment into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;        // the offered token yields at least one segment
    logic seg_last;  // the segment now being produced ends the token
    logic out_free;  // the output register can take a segment this cycle
  } status_t;

  // Effective row width: values outside the supported range are clipped.
  function automatic logic [12:0] clamp_width(input logic [12:0] value);
    logic [12:0] result;
    result = value;
    if (value < WIDTH_MIN) begin
      result = WIDTH_MIN;
    end else if (value > WIDTH_MAX) begin
      result = WIDTH_MAX;
    end
    return result;
  endfunction

endpackage

@@ hdl/rlid_ctrl.sv @@
// Controller state machine of the run-length image decoder.
module rlid_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rlid_pkg::status_t stat,
  output rlid_pkg::cmd_t   cmd
);
  import rlid_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign in_stall = (state != S_IDLE);
  assign cmd.load = in_valid && (state == S_IDLE);
  assign cmd.step = (state == S_RUN) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load && stat.go) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.step && stat.seg_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/rlid_dp.sv @@
// Datapath of the run-length image decoder: position, run state and output register.
module rlid_dp (
  input  logic              clk,
  input  logic              rst,
  input  rlid_pkg::cmd_t    cmd,
  output rlid_pkg::status_t stat,
  input  logic [23:0]       token,
  input  logic [12:0]       width,
  input  logic [12:0]       height,
  input  logic [11:0]       origin_x,
  input  logic [11:0]       origin_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [12:0]       seg_x,
  output logic [12:0]       seg_y,
  output logic [11:0]       seg_length,
  output logic [7:0]        seg_color,
  output logic              last
);
  import rlid_pkg::*;

  `include "assert_macros.svh"

  logic [11:0] column;
  logic [12:0] row;
  logic [11:0] len;
  logic [7:0]  color;
  logic [7:0]  color2;
  logic        pair;

  // Token decode.
  logic [11:0] tok_high;
  logic [11:0] tok_low;
  logic        tok_pair;
  logic [11:0] tok_len;
  logic        tok_can;
  logic        wrap0;
  logic [11:0] col_fix;
  logic [12:0] row_fix;

  // Segment step.
  logic [12:0] col13;
  logic [12:0] room;
  logic [11:0] seg_len;
  logic [11:0] rem;
  logic [12:0] col_sum;
  logic        wrap;
  logic [11:0] col_after;
  logic [12:0] row_after;
  logic        run_done;

  assign tok_high = token[23:12];
  assign tok_low  = token[11:0];
  assign tok_pair = tok_high[11];
  assign tok_len  = tok_pair ? 12'd1 : tok_low;
  assign col13    = {1'b0, column};

  // A column left beyond a lowered width wraps before the first pixel.
  assign tok_can = (tok_len != 12'd0) && (row < height);
  assign wrap0   = (col13 >= width);
  assign col_fix = wrap0 ? 12'd0 : column;
  assign row_fix = wrap0 ? row + 13'd1 : row;
  assign stat.go = tok_can && (row_fix < height);

  assign room      = width - col13;
  assign seg_len   = ({1'b0, len} < room) ? len : room[11:0];
  assign rem       = len - seg_len;
  assign col_sum   = col13 + {1'b0, seg_len};
  assign wrap      = (col_sum >= width);
  assign col_after = wrap ? 12'd0 : col_sum[11:0];
  assign row_after = wrap ? row + 13'd1 : row;
  assign run_done  = (rem == 12'd0);

  assign stat.seg_last = (run_done && !pair) || (row_after >= height);
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (cmd.load) begin
      if (tok_can) begin
        column <= col_fix;
        row    <= row_fix;
      end
    end else if (cmd.step) begin
      column <= col_after;
      row    <= row_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len    <= tok_len;
      color  <= tok_high[7:0];
      color2 <= tok_low[7:0];
      pair   <= tok_pair;
    end else if (cmd.step) begin
      if (run_done && pair) begin
        len   <= 12'd1;
        color <= color2;
        pair  <= 1'b0;
      end else begin
        len <= rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      seg_x      <= {1'b0, origin_x} + col13;
      seg_y      <= {1'b0, origin_y} + row;
      seg_length <= seg_len;
      seg_color  <= color;
      last       <= stat.seg_last;
    end
  end

  `RLID_ASSERT(a_row_inside, cmd.step |-> (row < height), "segment row beyond image height")
  `RLID_ASSERT(a_col_inside, cmd.step |-> (col13 < width), "segment column beyond row width")
  `RLID_ASSERT(a_seg_nonzero, cmd.step |-> (seg_len != 12'd0), "empty segment produced")
  `RLID_NEVER(a_load_and_step, cmd.load && cmd.step, "token load during segment production")

endmodule

@@ hdl/run_length_image_decoder.sv @@
// Top level of the run-length image decoder: configuration registers and wiring.
//
//  Channel  Direction  Handshake            Contents
//  token    in         in_valid / in_stall  token
//  segment  out        out_valid/out_stall  seg_x, seg_y, seg_length, seg_color, last
//  config   in         cfg_write            cfg_index, cfg_data
//
// A token is taken while the controller is idle; the segments it causes are then made
// one after another by the segment unit, and no new token is taken before the last
// of them. A token that causes nothing leaves the controller idle and the input
// unstalled.
// The one segment unit in the datapath is shared by every segment of a token.
// Reset is synchronous and active high; it restores the register defaults and puts
// the drawing position at the top-left corner. A stall on the output holds the
// segment loop, and the input stays stalled until the token's last segment is made.
module run_length_image_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] token,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] seg_x,
  output logic [12:0] seg_y,
  output logic [11:0] seg_length,
  output logic [7:0]  seg_color,
  output logic        last,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import rlid_pkg::*;

  // The width register holds the effective width: out-of-range values are
  // clipped when written, so the datapath never sees them.
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [11:0] origin_x;
  logic [11:0] origin_y;

  cmd_t    cmd;
  status_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= clamp_width(cfg_data);
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_ORIGIN_X:     origin_x     <= cfg_data[11:0];
        REG_ORIGIN_Y:     origin_y     <= cfg_data[11:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  // The controller decides when a token transfer is taken and when the
  // datapath advances by one segment.
  rlid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath keeps the drawing position, the run in progress and the
  // output register that parts the segment loop from the consumer.
  rlid_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .token      (token),
    .width      (image_width),
    .height     (image_height),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .seg_x      (seg_x),
    .seg_y      (seg_y),
    .seg_length (seg_length),
    .seg_color  (seg_color),
    .last       (last)
  );

endmodule

@@ tb/run_length_image_decoder_test.sv @@
// Self-checking testbench for the run-length image decoder: directed and randomised token streams.
module run_length_image_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlid_pkg::*;

  // One row segment as the block reports it.
  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [11:0] length;
    logic [7:0]  color;
    logic        last;
  } segment_t;

  // The longest run of cycles without any transfer before the run is abandoned.
  // The deliberate output hold below is the longest legitimate silence.
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  // Cycles allowed after the last segment for a token that caused nothing to clear.
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] token;
  logic        out_valid;
  logic        out_stall;
  logic [12:0] seg_x;
  logic [12:0] seg_y;
  logic [11:0] seg_length;
  logic [7:0]  seg_color;
  logic        last;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  run_length_image_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .token      (token),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .seg_x      (seg_x),
    .seg_y      (seg_y),
    .seg_length (seg_length),
    .seg_color  (seg_color),
    .last       (last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // The testbench's own copy of the configuration and of the drawing position.
  // Column and row are held as integers; the row is kept to 13 bits as in the block.
  logic [12:0] pic_width  = WIDTH_RESET;
  logic [12:0] pic_height = HEIGHT_RESET;
  logic [11:0] org_x      = '0;
  logic [11:0] org_y      = '0;
  int          cur_col    = 0;
  int          cur_row    = 0;

  // Segments still owed by the block, oldest first.
  segment_t pending_segs[$];

  // The most recent segment of the token being decoded is held back one step so
  // that its last flag can be set once the token is known to cause no more.
  segment_t held_seg;
  bit       held_valid;

  int mismatches     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 0;

  // A free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Lay down count pixels of one colour from the current position, splitting them
  // into row segments. A column left beyond a narrowed row wraps before anything is
  // placed, and nothing is placed once the image height has been filled.
  task automatic place_pixels(input int count, input logic [7:0] color);
    int w;
    int room;
    int span;
    w = (pic_width < WIDTH_MIN) ? WIDTH_MIN : ((pic_width > WIDTH_MAX) ? WIDTH_MAX : pic_width);
    while (count > 0 && cur_row < pic_height) begin
      if (cur_col >= w) begin
        cur_col = 0;
        cur_row = (cur_row + 1) & 'h1FFF;
      end
      if (cur_row < pic_height) begin
        room = w - cur_col;
        span = (count < room) ? count : room;
        if (held_valid) begin
          pending_segs.push_back(held_seg);
        end
        held_seg = '{x: 13'(org_x + cur_col), y: 13'(org_y + cur_row),
                     length: 12'(span), color: color, last: 1'b0};
        held_valid = 1'b1;
        count -= span;
        cur_col += span;
        if (cur_col >= w) begin
          cur_col = 0;
          cur_row = (cur_row + 1) & 'h1FFF;
        end
      end else begin
        count = 0;
      end
    end
  endtask

  // Work out every segment that one accepted token causes and queue them.
  // A high half above 2047 means a pair of single pixels; otherwise the token is
  // a run whose length is the low half and whose colour is the high half's low byte.
  task automatic decode_token(input logic [23:0] value);
    logic [11:0] hi;
    logic [11:0] lo;
    hi = value[23:12];
    lo = value[11:0];
    held_valid = 1'b0;
    if (hi > 12'd2047) begin
      place_pixels(1, hi[7:0]);
      place_pixels(1, lo[7:0]);
    end else begin
      place_pixels(int'(lo), hi[7:0]);
    end
    if (held_valid) begin
      held_seg.last = 1'b1;
      pending_segs.push_back(held_seg);
    end
  endtask

  // Offer one token. Inputs change only at the falling edge; the transfer is seen at
  // the rising edge where in_valid is high and in_stall is low. Valid is only lowered
  // for the idle cycles chosen here, so it is never dropped and raised in one step.
  task automatic send_token(input logic [23:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      token    <= 24'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    token    <= value;
    do @(posedge clk); while (in_stall);
    decode_token(value);
  endtask

  // Stop offering tokens and wait until every owed segment has arrived, then allow
  // SETTLE_CYCLES for a token that caused nothing to leave the block.
  task automatic wait_for_segments();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one configuration register and mirror it in the testbench's copy.
  // Only called while the block is idle.
  task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (index)
      REG_IMAGE_WIDTH:  pic_width  = value;
      REG_IMAGE_HEIGHT: pic_height = value;
      REG_ORIGIN_X:     org_x      = value[11:0];
      REG_ORIGIN_Y:     org_y      = value[11:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [12:0] w, input logic [12:0] h,
                              input logic [11:0] ox, input logic [11:0] oy);
    wait_for_segments();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_ORIGIN_X, {1'b0, ox});
    write_reg(REG_ORIGIN_Y, {1'b0, oy});
  endtask

  // A height some rows beyond the current one, so that the image fills part-way
  // through a phase, capped at the largest value the register holds.
  function automatic logic [12:0] height_ahead(input int rows);
    int h;
    h = cur_row + rows;
    return (h > 8191) ? 13'd8191 : 13'(h);
  endfunction

  // Mostly well-formed runs and pixel pairs with random content; the rest are
  // zero-length runs, very long runs and arbitrary tokens.
  function automatic logic [23:0] random_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return {12'($urandom_range(0, 2047)), 12'($urandom_range(1, 300))};
    end else if (pick < 60) begin
      return {12'($urandom_range(2048, 4095)), 12'($urandom)};
    end else if (pick < 68) begin
      return {12'($urandom_range(0, 2047)), 12'($urandom_range(1000, 4095))};
    end else if (pick < 73) begin
      return {12'($urandom_range(0, 2047)), 12'd0};
    end
    return 24'($urandom);
  endfunction

  // Pick a fresh geometry, with the limits of each register and the clipped widths
  // below 128 and above 4096 turning up regularly.
  task automatic random_geometry();
    logic [12:0] w;
    logic [12:0] h;
    logic [11:0] ox;
    logic [11:0] oy;
    case ($urandom_range(5))
      0:       w = WIDTH_MIN;
      1:       w = WIDTH_MAX;
      2:       w = 13'($urandom_range(0, 127));
      3:       w = 13'($urandom_range(4097, 8191));
      default: w = 13'($urandom_range(128, 4096));
    endcase
    wait_for_segments();
    h = ($urandom_range(3) == 0) ? 13'd8191 : height_ahead($urandom_range(10, 150));
    case ($urandom_range(2))
      0:       ox = 12'd0;
      1:       ox = 12'd4095;
      default: ox = 12'($urandom);
    endcase
    case ($urandom_range(2))
      0:       oy = 12'd0;
      1:       oy = 12'd4095;
      default: oy = 12'($urandom);
    endcase
    set_geometry(w, h, ox, oy);
  endtask

  // Reset values: short and long runs, pixel pairs and the extremes of the token.
  task automatic test_reset_defaults();
    send_token(24'h003005);
    send_token(24'h000000);
    send_token(24'hFFFFFF);
    send_token(24'h800000);
    send_token(24'h7FFFFF);
    send_token(24'h0AB13F);
    send_token(24'h05A001);
    send_token(24'h9C3E7A);
  endtask

  // Row wrapping at the widest row, and a row narrowed below the current column,
  // with widths outside the supported range clipped at both ends.
  task automatic test_width_wrap();
    set_geometry(WIDTH_MAX, 13'd8191, 12'd0, 12'd0);
    send_token(24'h011BB8);
    wait_for_segments();
    write_reg(REG_IMAGE_WIDTH, 13'd5);
    send_token(24'h02200A);
    wait_for_segments();
    write_reg(REG_IMAGE_WIDTH, 13'd8191);
    send_token(24'h033FFF);
    wait_for_segments();
    write_reg(REG_IMAGE_WIDTH, 13'd200);
    send_token(24'h044100);
  endtask

  // A run cut short by the last row, tokens after the image is full, a pixel pair
  // whose second pixel falls beyond the image, and a height of zero.
  task automatic test_image_filled();
    wait_for_segments();
    set_geometry(WIDTH_MIN, height_ahead(1), 12'd0, 12'd0);
    send_token(24'h05512C);
    send_token(24'h900901);
    send_token(24'h066010);
    wait_for_segments();
    write_reg(REG_IMAGE_HEIGHT, height_ahead(1));
    send_token(24'h07707F);
    send_token(24'hA5A5A5);
    wait_for_segments();
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    send_token(24'h088020);
    send_token(24'hC0FFEE);
  endtask

  // Largest origins, so that the starting column reaches the top of its range.
  task automatic test_origin_limits();
    set_geometry(WIDTH_MAX, 13'd8191, 12'd4095, 12'd4095);
    send_token(24'h0DDFFF);
    send_token(24'hFEDCBA);
  endtask

  // Random tokens under one idling pattern, with a new geometry half-way through.
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i == 0 || i == count / 2) begin
        random_geometry();
      end
      send_token(random_token());
    end
  endtask

  // The receiver holds off for a long stretch while tokens keep coming, so that the
  // block fills and stalls its input.
  task automatic test_output_hold();
    set_geometry(13'd320, 13'd8191, 12'($urandom), 12'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_token(random_token());
    end
  endtask

  // The sender goes quiet until every owed segment has come, then resumes.
  task automatic test_sender_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    for (int i = 0; i < 10; i++) begin
      send_token(random_token());
    end
    wait_for_segments();
    for (int i = 0; i < 10; i++) begin
      send_token(random_token());
    end
  endtask

  // Long runs on the narrowest row drive the row count past 4096, so that the top
  // origin plus the row overflows 13 bits and must wrap.
  task automatic test_deep_rows();
    int n;
    n = 0;
    set_geometry(WIDTH_MIN, 13'd8191, 12'($urandom), 12'd4095);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    while (cur_row < 4300 && n < 220) begin
      if ($urandom_range(3) == 0) begin
        send_token(random_token());
      end else begin
        send_token({12'($urandom_range(0, 2047)), 12'($urandom_range(3800, 4095))});
      end
      n++;
    end
  endtask

  // Receiver side: random stalls at the chosen rate, or one long hold when asked.
  // The hold is counted here in cycles, independently of the sender.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic report_segment(input string what, input segment_t want, input segment_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected x=%0d y=%0d len=%0d colour=%0d last=%0b,",
               $realtime, what, want.x, want.y, want.length, want.color, want.last);
      $display("    got x=%0d y=%0d len=%0d colour=%0d last=%0b",
               got.x, got.y, got.length, got.color, got.last);
    end
  endtask

  // Every segment transfer is checked against the oldest owed segment. Outputs are
  // read at the rising edge, before the block's registers move on.
  always @(posedge clk) begin : segment_check
    segment_t got;
    segment_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{x: seg_x, y: seg_y, length: seg_length, color: seg_color, last: last};
      if (pending_segs.size() == 0) begin
        report_segment("segment with none owed", '0, got);
      end else begin
        want = pending_segs.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.length !== want.length ||
            got.color !== want.color || got.last !== want.last) begin
          report_segment("segment mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("run_length_image_decoder verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset once, the directed cases, the random phases, then the hold, pause
  // and deep-row cases, and finally a drain before the verdict.
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    token     = '0;
    cfg_write = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_width_wrap();
    test_image_filled();
    test_origin_limits();
    test_random_phase(0, 0, 70);
    test_random_phase(59, 0, 70);
    test_random_phase(0, 59, 70);
    test_random_phase(12, 12, 70);
    test_output_hold();
    test_sender_pause();
    test_deep_rows();

    wait_for_segments();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_segs.size() == 0) begin
      $display("run_length_image_decoder verification clean");
    end else begin
      $display("run_length_image_decoder verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rlid_pkg.sv
hdl/rlid_ctrl.sv
hdl/rlid_dp.sv
hdl/run_length_image_decoder.sv
tb/run_length_image_decoder_test.sv
